// ===== rtl/ddo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for differential drive odometry
// Holds the CORDIC arctangent table, gain, heading and divide constants, the
// register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package ddo_pkg;

   localparam int ATAN_ENTRIES = 24;
   localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;
   localparam logic [19:0] HEAD_MUL = 20'd699971;
   localparam int HEAD_SHIFT = 26;
   // ceil(2^51 / 15625): exact floor division by 15625 for dividends below 2^37
   localparam logic [37:0] DIV_RECIP = 38'd144115188076;
   localparam logic [1:0] REG_RATE = 2'd0;
   localparam logic [1:0] REG_RADIUS = 2'd1;
   localparam logic [1:0] REG_ITRACK = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WHEEL,
      ST_SPEED,
      ST_VTH,
      ST_CORD,
      ST_VEL,
      ST_ABS,
      ST_DIVL,
      ST_DIVH,
      ST_POS,
      ST_HEAD,
      ST_HUPD,
      ST_CORD2,
      ST_VEL2,
      ST_CORD3,
      ST_DONE
   } state_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'h20000000;
            5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;
            5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;
            5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ddo_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cordic: iterative rotation CORDIC
// One micro-rotation per cycle on a binary angle; gives cos and sin in Q5.30.
// ----------------------------------------------------------------------------
module ddo_cordic #(
   parameter int STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [31:0]        angle,
   output logic                    done,
   output logic signed [34:0]      cos_out,
   output logic signed [34:0]      sin_out
);
   import ddo_pkg::*;

   localparam int NSTEP = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;

   logic signed [34:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic busy_ff, busy_in, flip_ff, flip_in, done_ff, done_in;
   logic [31:0] rot;
   logic flip;
   logic signed [34:0] dx, dy;

   always_comb begin
      flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
      rot = flip ? angle + 32'h80000000 : angle;
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; flip_in = flip_ff; done_in = 1'b0;
      if (start) begin
         x_in = CORDIC_GAIN; y_in = '0;
         z_in = {{2{rot[31]}}, rot};
         i_in = '0; busy_in = 1'b1; flip_in = flip;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx; y_in = y_ff + dy;
            z_in = z_ff - $signed({2'b00, atan_bam(i_ff)});
         end else begin
            x_in = x_ff + dx; y_in = y_ff - dy;
            z_in = z_ff + $signed({2'b00, atan_bam(i_ff)});
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(NSTEP - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in; flip_ff <= flip_in;
   end

   assign done = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
endmodule
`default_nettype wire

// ===== rtl/diff_drive_odometry.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_odometry: dead-reckoning pose from wheel speed readings
// Input channel req_*: left/right raw servo readings and dt in microseconds.
// Result channel rsp_*: pose, yaw quaternion, world velocity and yaw rate.
// A transfer happens when valid is high and stall is low.
// Config port csr_*: index 0 rate scale, 1 wheel radius, 2 inverse track;
// other indexes are dropped. Write only while idle.
// One item at a time: each item takes three passes through one shared
// iterative CORDIC plus a short multiply/divide sequence, and req_stall
// is high while busy. The result sits in an output register until taken;
// a stalled result holds the block. Reset clears pose and heading to zero
// and loads the register defaults.
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [10:0]         req_left_raw,
   input  wire logic [10:0]         req_right_raw,
   input  wire logic [19:0]         req_dt_us,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_pos_x,
   output logic signed [31:0]       rsp_pos_y,
   output logic [31:0]              rsp_heading,
   output logic signed [15:0]       rsp_quat_z,
   output logic signed [15:0]       rsp_quat_w,
   output logic signed [23:0]       rsp_vel_x,
   output logic signed [23:0]       rsp_vel_y,
   output logic signed [23:0]       rsp_yaw_rate,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [23:0]         csr_data
);
   import ddo_pkg::*;

   state_type st_ff, st_in;
   logic [23:0] rate_ff;
   logic [15:0] rad_ff;
   logic [23:0] itrack_ff;
   logic signed [31:0] x_ff, y_ff;
   logic [31:0] hd_ff;
   logic signed [11:0] cl_ff, cr_ff;
   logic [19:0] dt_ff;
   logic signed [36:0] wl_ff, wr_ff;
   logic signed [23:0] v_ff, vth_ff, vx_ff, vy_ff;
   logic signed [15:0] qz_ff, qw_ff;
   logic signed [43:0] dx_ff, dy_ff;
   logic signed [63:0] dth_ff;
   logic [36:0] nx_ff, ny_ff;
   logic [74:0] px_ff, py_ff;

   logic cstart, cdone;
   logic [31:0] cang;
   logic signed [34:0] ccos, csin;

   ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cstart), .angle(cang),
      .done(cdone), .cos_out(ccos), .sin_out(csin)
   );

   function automatic logic signed [23:0] sat24(input logic signed [63:0] a);
      if (a > 64'sd8388607) return 24'sh7FFFFF;
      if (a < -64'sd8388608) return 24'sh800000;
      return a[23:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [34:0] a);
      logic signed [34:0] s;
      begin
         s = a >>> 15;
         if (s > 35'sd32767) return 16'sh7FFF;
         if (s < -35'sd32768) return 16'sh8000;
         return s[15:0];
      end
   endfunction

   function automatic logic signed [31:0] addsat(input logic signed [31:0] a,
                                                 input logic signed [43:0] b);
      logic signed [44:0] s;
      begin
         s = 45'(a) + 45'(b);
         if (s > 45'sd2147483647) return 32'sh7FFFFFFF;
         if (s < -45'sd2147483648) return 32'sh80000000;
         return s[31:0];
      end
   endfunction

   // magnitude over 64; 1e6 = 64 * 15625, the rest by reciprocal multiply
   function automatic logic [36:0] mag_div64(input logic signed [43:0] a);
      logic [43:0] m;
      begin
         m = a[43] ? 44'(-a) : 44'(a);
         return m[42:6];
      end
   endfunction

   logic signed [37:0] ws, wd;
   logic [18:0] kdiv;
   logic [55:0] prodx, prody;
   logic signed [43:0] qx, qy;

   always_comb begin
      st_in = st_ff;
      cstart = 1'b0;
      cang = hd_ff;
      ws = 38'(wr_ff) + 38'(wl_ff);
      wd = 38'(wr_ff) - 38'(wl_ff);
      // reciprocal split in two halves, one half per cycle
      kdiv = (st_ff == ST_DIVH) ? DIV_RECIP[37:19] : DIV_RECIP[18:0];
      prodx = nx_ff * kdiv;
      prody = ny_ff * kdiv;
      // quotient toward zero: sign of the dividend on the floored magnitude
      qx = dx_ff[43] ? -$signed({20'd0, px_ff[74:51]}) : $signed({20'd0, px_ff[74:51]});
      qy = dy_ff[43] ? -$signed({20'd0, py_ff[74:51]}) : $signed({20'd0, py_ff[74:51]});
      case (st_ff)
         ST_IDLE: if (req_valid) st_in = ST_WHEEL;
         ST_WHEEL: st_in = ST_SPEED;
         ST_SPEED: st_in = ST_VTH;
         ST_VTH: begin
            cstart = 1'b1; st_in = ST_CORD;
         end
         ST_CORD: if (cdone) st_in = ST_VEL;
         ST_VEL: st_in = ST_ABS;
         ST_ABS: st_in = ST_DIVL;
         ST_DIVL: st_in = ST_DIVH;
         ST_DIVH: st_in = ST_POS;
         ST_POS: st_in = ST_HEAD;
         ST_HEAD: st_in = ST_HUPD;
         ST_HUPD: begin
            // rotate by the heading being written this cycle
            cstart = 1'b1; cang = hd_ff + dth_ff[31:0]; st_in = ST_CORD2;
         end
         ST_CORD2: if (cdone) st_in = ST_VEL2;
         ST_VEL2: begin
            cstart = 1'b1; cang = {1'b0, hd_ff[31:1]}; st_in = ST_CORD3;
         end
         ST_CORD3: if (cdone) st_in = ST_DONE;
         ST_DONE: if (!rsp_stall) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rate_ff <= 24'd200287; rad_ff <= 16'd3179; itrack_ff <= 24'd211406;
         x_ff <= '0; y_ff <= '0; hd_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RATE: rate_ff <= csr_data;
               REG_RADIUS: rad_ff <= csr_data[15:0];
               REG_ITRACK: itrack_ff <= csr_data;
               default: ;
            endcase
         end
         if (st_ff == ST_POS) begin
            x_ff <= addsat(x_ff, qx);
            y_ff <= addsat(y_ff, qy);
         end
         if (st_ff == ST_HUPD) hd_ff <= hd_ff + dth_ff[31:0];
      end
      case (st_ff)
         ST_IDLE: begin
            cl_ff <= (req_left_raw > 11'd1023) ? -$signed({1'b0, req_left_raw - 11'd1023})
                                               : $signed({1'b0, req_left_raw});
            cr_ff <= (req_right_raw > 11'd1023) ? $signed({1'b0, req_right_raw - 11'd1023})
                                                : -$signed({1'b0, req_right_raw});
            dt_ff <= req_dt_us;
         end
         ST_WHEEL: begin
            wl_ff <= 37'(cl_ff * $signed({1'b0, rate_ff}));
            wr_ff <= 37'(cr_ff * $signed({1'b0, rate_ff}));
         end
         ST_SPEED: begin
            v_ff <= sat24(64'(($signed({1'b0, rad_ff}) * ws) >>> 25));
            dth_ff <= 64'(($signed({1'b0, rad_ff}) * wd) >>> 24);
         end
         ST_VTH: vth_ff <= sat24(64'(($signed(dth_ff[28:0]) * $signed({1'b0, itrack_ff}))
                                     >>> 16));
         ST_CORD: if (cdone) begin
            vx_ff <= sat24(64'((v_ff * ccos) >>> 30));
            vy_ff <= sat24(64'((v_ff * csin) >>> 30));
         end
         ST_VEL: begin
            dx_ff <= 44'(vx_ff * $signed({1'b0, dt_ff}));
            dy_ff <= 44'(vy_ff * $signed({1'b0, dt_ff}));
            dth_ff <= 64'(vth_ff * $signed({1'b0, dt_ff}));
         end
         ST_ABS: begin
            nx_ff <= mag_div64(dx_ff);
            ny_ff <= mag_div64(dy_ff);
         end
         ST_DIVL: begin
            px_ff <= {19'd0, prodx};
            py_ff <= {19'd0, prody};
         end
         ST_DIVH: begin
            px_ff <= px_ff + {prodx, 19'd0};
            py_ff <= py_ff + {prody, 19'd0};
         end
         ST_HEAD: dth_ff <= 64'(($signed(dth_ff[43:0]) * $signed({1'b0, HEAD_MUL}))
                                >>> HEAD_SHIFT);
         ST_CORD2: if (cdone) begin
            vx_ff <= sat24(64'((v_ff * ccos) >>> 30));
            vy_ff <= sat24(64'((v_ff * csin) >>> 30));
         end
         ST_CORD3: if (cdone) begin
            qz_ff <= sat16(csin);
            qw_ff <= sat16(ccos);
         end
         default: ;
      endcase
   end

   assign req_stall = (st_ff != ST_IDLE);
   assign csr_ready = (st_ff == ST_IDLE);
   assign rsp_valid = (st_ff == ST_DONE);
   assign rsp_pos_x = x_ff;
   assign rsp_pos_y = y_ff;
   assign rsp_heading = hd_ff;
   assign rsp_quat_z = qz_ff;
   assign rsp_quat_w = qw_ff;
   assign rsp_vel_x = vx_ff;
   assign rsp_vel_y = vy_ff;
   assign rsp_yaw_rate = vth_ff;
endmodule
`default_nettype wire
